// ----- rtl/rolq_pkg.sv -----
// Shared types and constants of the ROI overlap lock qualifier.
package rolq_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int RATIO_W    = 8;

	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	localparam cfg_idx_t REG_LOCK_HOLD   = 2'd0;
	localparam cfg_idx_t REG_APPROVAL    = 2'd1;
	localparam cfg_idx_t REG_MIN_OVERLAP = 2'd2;

	localparam cfg_data_t RST_LOCK_HOLD   = 8'd10;
	localparam cfg_data_t RST_APPROVAL    = 8'd3;
	localparam cfg_data_t RST_MIN_OVERLAP = 8'd128;

	typedef logic [1:0] mul_op_t;

	localparam mul_op_t MUL_NONE  = 2'd0;
	localparam mul_op_t MUL_INTER = 2'd1;
	localparam mul_op_t MUL_RW    = 2'd2;
	localparam mul_op_t MUL_RWH   = 2'd3;

	typedef struct packed {
		logic    capture;
		logic    mul_en;
		mul_op_t op;
		logic    decide;
	} cmd_t;

	typedef struct packed {
		logic needs_test;
		logic out_free;
	} stat_t;

endpackage

// ----- rtl/rolq_ctrl.sv -----
// Sequencer of the ROI overlap lock qualifier: input transfer, multiply steps, decision.
module rolq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rolq_pkg::stat_t stat,
	output rolq_pkg::cmd_t  cmd
);
	import rolq_pkg::*;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_MUL_I   = 3'd1;
	localparam logic [2:0] S_MUL_RW  = 3'd2;
	localparam logic [2:0] S_MUL_RWH = 3'd3;
	localparam logic [2:0] S_DECIDE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.mul_en  = 1'b0;
		cmd.op      = MUL_NONE;
		cmd.decide  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					// skip the ratio test when locked or nothing was found
					state_d = stat.needs_test ? S_MUL_I : S_DECIDE;
				end
			end
			S_MUL_I: begin
				cmd.mul_en = 1'b1;
				cmd.op     = MUL_INTER;
				state_d    = S_MUL_RW;
			end
			S_MUL_RW: begin
				cmd.mul_en = 1'b1;
				cmd.op     = MUL_RW;
				state_d    = S_MUL_RWH;
			end
			S_MUL_RWH: begin
				cmd.mul_en = 1'b1;
				cmd.op     = MUL_RWH;
				state_d    = S_DECIDE;
			end
			S_DECIDE: begin
				// hold until the result register can take the new result
				if (stat.out_free) begin
					cmd.decide = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != S_IDLE)
		else $error("input transfer did not start work");

	a_decide_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decide |=> state_q == S_IDLE && in_ready)
		else $error("decision did not return to idle");

	a_mul_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL_I |=> state_q == S_MUL_RW ##1 state_q == S_MUL_RWH
		##1 state_q == S_DECIDE)
		else $error("multiply steps out of order");
`endif

endmodule

// ----- rtl/rolq_dp.sv -----
// Datapath of the ROI overlap lock qualifier: spans, shared multiplier, counters, result register.
module rolq_dp #(
	parameter int COORD_BITS = 12,
	parameter int COUNT_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rolq_pkg::cmd_t            cmd,
	output rolq_pkg::stat_t           stat,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  rolq_pkg::cfg_idx_t        cfg_index,
	input  rolq_pkg::cfg_data_t       cfg_data,
	input  logic                      found,
	input  logic [COORD_BITS-1:0]     roi_x,
	input  logic [COORD_BITS-1:0]     roi_y,
	input  logic [COORD_BITS-1:0]     roi_w,
	input  logic [COORD_BITS-1:0]     roi_h,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      crop_enable,
	output logic [COORD_BITS-1:0]     offset_x,
	output logic [COORD_BITS-1:0]     offset_y
);
	import rolq_pkg::*;

	localparam int MA_W   = COORD_BITS + RATIO_W;
	localparam int PROD_W = MA_W + COORD_BITS;
	localparam int INTER_W = 2 * COORD_BITS;

	// overlap length of [a0, a0+aw) and [b0, b0+bw), edges computed without wrap
	function automatic logic [COORD_BITS-1:0] span(
		input logic [COORD_BITS-1:0] a0,
		input logic [COORD_BITS-1:0] aw,
		input logic [COORD_BITS-1:0] b0,
		input logic [COORD_BITS-1:0] bw
	);
		logic [COORD_BITS:0] lo;
		logic [COORD_BITS:0] hi;
		logic [COORD_BITS:0] ae;
		logic [COORD_BITS:0] be;
		logic [COORD_BITS:0] diff;
		ae   = {1'b0, a0} + {1'b0, aw};
		be   = {1'b0, b0} + {1'b0, bw};
		lo   = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
		hi   = (ae < be) ? ae : be;
		diff = hi - lo;
		return (hi > lo) ? diff[COORD_BITS-1:0] : '0;
	endfunction

	logic                  found_q;
	logic [COORD_BITS-1:0] x_q, y_q, w_q, h_q;
	logic [COORD_BITS-1:0] last_x_q, last_y_q, last_w_q, last_h_q;
	logic [COORD_BITS-1:0] iw_q, ih_q;
	logic [PROD_W-1:0]     mul_q;
	logic [INTER_W-1:0]    inter_q;
	logic [COUNT_BITS-1:0] hold_q, appr_q;
	logic [COUNT_BITS-1:0] lock_hold_q, appr_frames_q;
	logic [RATIO_W-1:0]    ratio_q;
	logic                  out_valid_q;
	logic                  crop_q;
	logic [COORD_BITS-1:0] off_x_q, off_y_q;

	logic [MA_W-1:0]       mul_a;
	logic [COORD_BITS-1:0] mul_b;
	logic [PROD_W-1:0]     mul_res;

	logic                  pass;
	logic [COUNT_BITS-1:0] appr_dec, appr_next, hold_dec;
	logic [COUNT_BITS-1:0] hold_d, appr_d;
	logic                  crop_d;

	assign cfg_ready       = 1'b1;
	assign stat.needs_test = found && (hold_q == '0);
	assign stat.out_free   = !out_valid_q || out_ready;

	always_comb begin
		case (cmd.op)
			MUL_INTER: begin
				mul_a = MA_W'(iw_q);
				mul_b = ih_q;
			end
			MUL_RW: begin
				mul_a = MA_W'(ratio_q);
				mul_b = w_q;
			end
			MUL_RWH: begin
				mul_a = mul_q[MA_W-1:0];
				mul_b = h_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_res = mul_a * mul_b;

	// intersection * 256 against ratio * area
	assign pass      = {inter_q, {RATIO_W{1'b0}}} > mul_q;
	assign appr_dec  = appr_q - COUNT_BITS'(1);
	assign appr_next = pass ? appr_dec : appr_frames_q;
	assign hold_dec  = hold_q - COUNT_BITS'(1);

	always_comb begin
		hold_d = hold_q;
		appr_d = appr_q;
		crop_d = 1'b0;
		if (found_q) begin
			if (hold_q != '0) begin
				hold_d = lock_hold_q;
				crop_d = 1'b1;
			end else if (appr_next == '0) begin
				hold_d = lock_hold_q;
				appr_d = appr_frames_q;
				crop_d = 1'b1;
			end else begin
				appr_d = appr_next;
			end
		end else if (hold_q != '0) begin
			hold_d = hold_dec;
			crop_d = (hold_dec != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_hold_q   <= COUNT_BITS'(RST_LOCK_HOLD);
			appr_frames_q <= COUNT_BITS'(RST_APPROVAL);
			ratio_q       <= RST_MIN_OVERLAP;
			hold_q        <= '0;
			appr_q        <= COUNT_BITS'(RST_APPROVAL);
			last_x_q      <= '0;
			last_y_q      <= '0;
			last_w_q      <= '0;
			last_h_q      <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LOCK_HOLD:   lock_hold_q   <= COUNT_BITS'(cfg_data);
					REG_APPROVAL:    appr_frames_q <= COUNT_BITS'(cfg_data);
					REG_MIN_OVERLAP: ratio_q       <= cfg_data;
					default: begin
					end
				endcase
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.decide) begin
				hold_q      <= hold_d;
				appr_q      <= appr_d;
				out_valid_q <= 1'b1;
				if (found_q) begin
					last_x_q <= x_q;
					last_y_q <= y_q;
					last_w_q <= w_q;
					last_h_q <= h_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			found_q <= found;
			x_q     <= roi_x;
			y_q     <= roi_y;
			w_q     <= roi_w;
			h_q     <= roi_h;
			iw_q    <= span(roi_x, roi_w, last_x_q, last_w_q);
			ih_q    <= span(roi_y, roi_h, last_y_q, last_h_q);
		end
		if (cmd.mul_en) begin
			mul_q <= mul_res;
			// keep the intersection before the area product takes the register
			if (cmd.op == MUL_RW) begin
				inter_q <= mul_q[INTER_W-1:0];
			end
		end
		if (cmd.decide) begin
			crop_q  <= crop_d;
			off_x_q <= crop_d ? x_q : '0;
			off_y_q <= crop_d ? y_q : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign crop_enable = crop_q;
	assign offset_x    = off_x_q;
	assign offset_y    = off_y_q;

`ifndef SYNTHESIS
	a_decide_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decide |-> !out_valid_q || out_ready)
		else $error("result register overwritten before transfer");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(crop_q) && $stable(off_x_q)
		&& $stable(off_y_q))
		else $error("result changed while waiting for transfer");

	a_mul_op_set: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_en |-> cmd.op != MUL_NONE)
		else $error("multiply step without an operand select");
`endif

endmodule

// ----- rtl/roi_overlap_lock_qualifier.sv -----
// Top level of the ROI overlap lock qualifier: sequencer plus datapath.
// One item per video frame: a found flag and a region. A found frame while unlocked
// goes through the transfer with overlap spans, three passes through the one shared
// multiplier for intersection, ratio*width and ratio*width*height, then the decision,
// which loads the result register. Any other frame goes from the transfer straight to
// the decision. One item is in work at a time; a finished result waits in the output
// register, and the decision of the next item waits while that register is still
// full. Configuration writes are taken every cycle; the hold and approval lengths
// apply at the next reload of their countdown, the overlap ratio at the next test.
module roi_overlap_lock_qualifier #(
	parameter int COORD_BITS = 12,
	parameter int COUNT_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  found,
	input  logic [COORD_BITS-1:0] roi_x,
	input  logic [COORD_BITS-1:0] roi_y,
	input  logic [COORD_BITS-1:0] roi_w,
	input  logic [COORD_BITS-1:0] roi_h,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  crop_enable,
	output logic [COORD_BITS-1:0] offset_x,
	output logic [COORD_BITS-1:0] offset_y,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  rolq_pkg::cfg_idx_t    cfg_index,
	input  rolq_pkg::cfg_data_t   cfg_data
);
	import rolq_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	rolq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rolq_dp #(
		.COORD_BITS (COORD_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.found       (found),
		.roi_x       (roi_x),
		.roi_y       (roi_y),
		.roi_w       (roi_w),
		.roi_h       (roi_h),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.crop_enable (crop_enable),
		.offset_x    (offset_x),
		.offset_y    (offset_y)
	);

endmodule
